// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the segment intersection RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NR(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/core/sit_pkg.sv =====
// Shared constants and types for the segment intersection test.
`default_nettype none

package sit_pkg;

    localparam int COORD_WIDTH_DEF = 24;

    // Cross-product terms, each a pair of products compared against each other.
    localparam int TERM_DEN  = 0;
    localparam int TERM_RN1  = 1;
    localparam int TERM_SN1  = 2;
    localparam int TERM_RN2  = 3;
    localparam int TERM_SN2  = 4;
    localparam int NUM_TERMS = 5;

    typedef struct packed {
        logic ax_ne_bx;
        logic ovl_x;
        logic ovl_y;
        logic shared_ep;
    } t_geo_flags;

endpackage

`default_nettype wire

// ===== rtl/core/sit_prod.sv =====
// Coordinate differences, registered products and endpoint comparisons.
`default_nettype none

module sit_prod
    import sit_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [COORD_WIDTH-1:0]       i_ax,
    input  logic signed [COORD_WIDTH-1:0]       i_ay,
    input  logic signed [COORD_WIDTH-1:0]       i_bx,
    input  logic signed [COORD_WIDTH-1:0]       i_by,
    input  logic signed [COORD_WIDTH-1:0]       i_cx,
    input  logic signed [COORD_WIDTH-1:0]       i_cy,
    input  logic signed [COORD_WIDTH-1:0]       i_dx,
    input  logic signed [COORD_WIDTH-1:0]       i_dy,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [2*COORD_WIDTH+1:0]     o_lhs [NUM_TERMS],
    output logic signed [2*COORD_WIDTH+1:0]     o_rhs [NUM_TERMS],
    output t_geo_flags                          o_flags
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] d_bax, d_bay, d_dcx, d_dcy, d_acx, d_acy;
    logic signed [DW-1:0] d_bdx, d_bdy, d_cdx, d_cdy, d_abx, d_aby;
    logic signed [PW-1:0] n_lhs [NUM_TERMS];
    logic signed [PW-1:0] n_rhs [NUM_TERMS];
    logic signed [PW-1:0] r_lhs [NUM_TERMS];
    logic signed [PW-1:0] r_rhs [NUM_TERMS];
    t_geo_flags           n_flags;
    t_geo_flags           r_flags;
    logic                 r_valid;

    // True when the spans [p0,p1] and [q0,q1] overlap by more than a point.
    function automatic logic strict_overlap(
        input logic signed [COORD_WIDTH-1:0] p0,
        input logic signed [COORD_WIDTH-1:0] p1,
        input logic signed [COORD_WIDTH-1:0] q0,
        input logic signed [COORD_WIDTH-1:0] q1
    );
        logic p_below;
        logic q_below;
        p_below = (p0 <= q0) && (p0 <= q1) && (p1 <= q0) && (p1 <= q1);
        q_below = (q0 <= p0) && (q0 <= p1) && (q1 <= p0) && (q1 <= p1);
        return !p_below && !q_below;
    endfunction

    assign d_bax = DW'(i_bx) - DW'(i_ax);
    assign d_bay = DW'(i_by) - DW'(i_ay);
    assign d_dcx = DW'(i_dx) - DW'(i_cx);
    assign d_dcy = DW'(i_dy) - DW'(i_cy);
    assign d_acx = DW'(i_ax) - DW'(i_cx);
    assign d_acy = DW'(i_ay) - DW'(i_cy);
    assign d_bdx = DW'(i_bx) - DW'(i_dx);
    assign d_bdy = DW'(i_by) - DW'(i_dy);
    assign d_cdx = DW'(i_cx) - DW'(i_dx);
    assign d_cdy = DW'(i_cy) - DW'(i_dy);
    assign d_abx = DW'(i_ax) - DW'(i_bx);
    assign d_aby = DW'(i_ay) - DW'(i_by);

    // The denominator seen from B and D equals the one from A and C, so it
    // is formed once.
    always_comb begin
        n_lhs[TERM_DEN] = d_bax * d_dcy;
        n_rhs[TERM_DEN] = d_bay * d_dcx;
        n_lhs[TERM_RN1] = d_acy * d_dcx;
        n_rhs[TERM_RN1] = d_acx * d_dcy;
        n_lhs[TERM_SN1] = d_acy * d_bax;
        n_rhs[TERM_SN1] = d_acx * d_bay;
        n_lhs[TERM_RN2] = d_bdy * d_cdx;
        n_rhs[TERM_RN2] = d_bdx * d_cdy;
        n_lhs[TERM_SN2] = d_bdy * d_abx;
        n_rhs[TERM_SN2] = d_bdx * d_aby;

        n_flags.ax_ne_bx  = (i_ax != i_bx);
        n_flags.ovl_x     = strict_overlap(i_ax, i_bx, i_cx, i_dx);
        n_flags.ovl_y     = strict_overlap(i_ay, i_by, i_cy, i_dy);
        n_flags.shared_ep = ((i_ax == i_cx) && (i_ay == i_cy))
                         || ((i_ax == i_dx) && (i_ay == i_dy))
                         || ((i_bx == i_cx) && (i_by == i_cy))
                         || ((i_bx == i_dx) && (i_by == i_dy));
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_lhs   <= n_lhs;
            r_rhs   <= n_rhs;
            r_flags <= n_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_lhs   = r_lhs;
    assign o_rhs   = r_rhs;
    assign o_flags = r_flags;

endmodule

`default_nettype wire

// ===== rtl/core/sit_decide.sv =====
// Product comparisons, intersection decision and the result register.
`default_nettype none

`include "assert_macros.svh"

module sit_decide
    import sit_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [2*COORD_WIDTH+1:0]     i_lhs [NUM_TERMS],
    input  logic signed [2*COORD_WIDTH+1:0]     i_rhs [NUM_TERMS],
    input  t_geo_flags                          i_flags,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_intersects
);

    logic [NUM_TERMS-1:0] pos;
    logic [NUM_TERMS-1:0] neg;
    logic                 den_zero;
    logic                 ok_ac;
    logic                 ok_bd;
    logic                 n_intersects;
    logic                 r_intersects;
    logic                 r_valid;

    always_comb begin
        for (int k = 0; k < NUM_TERMS; k++) begin
            pos[k] = (i_lhs[k] > i_rhs[k]);
            neg[k] = (i_lhs[k] < i_rhs[k]);
        end
    end

    assign den_zero = !pos[TERM_DEN] && !neg[TERM_DEN];

    // Numerators may be zero but must not oppose the denominator's sign.
    assign ok_ac = pos[TERM_DEN] ? (!neg[TERM_RN1] && !neg[TERM_SN1])
                                 : (!pos[TERM_RN1] && !pos[TERM_SN1]);
    assign ok_bd = pos[TERM_DEN] ? (!neg[TERM_RN2] && !neg[TERM_SN2])
                                 : (!pos[TERM_RN2] && !pos[TERM_SN2]);

    always_comb begin
        if (den_zero) begin
            // Parallel: collinear and overlapping along x, or y if vertical.
            n_intersects = !pos[TERM_RN1] && !neg[TERM_RN1]
                        && (i_flags.ax_ne_bx ? i_flags.ovl_x : i_flags.ovl_y);
        end else begin
            n_intersects = !i_flags.shared_ep && ok_ac && ok_bd;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_intersects <= n_intersects;
        end
    end

    assign o_valid      = r_valid;
    assign o_intersects = r_intersects;

    `ASSERT_CLK(a_out_from_prod, i_clk, i_rst_n, $rose(o_valid) |-> $past(i_valid), "result beat without a product beat")
    `ASSERT_CLK(a_shared_ep_zero, i_clk, i_rst_n, (i_valid && o_ready && !den_zero && i_flags.shared_ep) |=> !o_intersects, "shared endpoint reported as crossing")

endmodule

`default_nettype wire

// ===== rtl/core/segment_intersection_test.sv =====
// Top level of the 2-D segment intersection test.
//
// Input channel: i_valid / o_ready with the four points A, B, C, D on
// i_ax .. i_dy, signed two's complement of COORD_WIDTH bits (Q16.8 at 24).
// Output channel: o_valid / i_ready with o_intersects, set when segment AB
// crosses CD or, for collinear segments, overlaps it by more than a point.
// A beat moves on a channel at a rising edge where its valid and ready are
// both high. Every input beat yields exactly one result beat, in order.
// The block is a three-register pipeline: input register, product register
// (ten signed products of (COORD_WIDTH+1)-bit differences), result register.
// An accepted input beat passes the input, product and result registers in turn
// before its result is presented; one beat per cycle is sustained while i_ready is high.
// When the receiver stalls, each stage holds its beat and the pipeline still
// fills empty stages, so up to three beats wait inside before o_ready drops.
// Reset (i_rst_n low at a clock edge) empties all stages; the block keeps
// no other state.
`default_nettype none

`include "assert_macros.svh"

module segment_intersection_test
    import sit_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_ax,
    input  logic signed [COORD_WIDTH-1:0] i_ay,
    input  logic signed [COORD_WIDTH-1:0] i_bx,
    input  logic signed [COORD_WIDTH-1:0] i_by,
    input  logic signed [COORD_WIDTH-1:0] i_cx,
    input  logic signed [COORD_WIDTH-1:0] i_cy,
    input  logic signed [COORD_WIDTH-1:0] i_dx,
    input  logic signed [COORD_WIDTH-1:0] i_dy,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_intersects
);

    localparam int PW = 2 * COORD_WIDTH + 2;

    logic                          r_in_valid;
    logic signed [COORD_WIDTH-1:0] r_ax, r_ay, r_bx, r_by;
    logic signed [COORD_WIDTH-1:0] r_cx, r_cy, r_dx, r_dy;
    logic                          prod_ready;
    logic                          prod_valid;
    logic                          dec_ready;
    logic signed [PW-1:0]          prod_lhs [NUM_TERMS];
    logic signed [PW-1:0]          prod_rhs [NUM_TERMS];
    t_geo_flags                    prod_flags;

    assign o_ready = !r_in_valid || prod_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_ax <= i_ax;
            r_ay <= i_ay;
            r_bx <= i_bx;
            r_by <= i_by;
            r_cx <= i_cx;
            r_cy <= i_cy;
            r_dx <= i_dx;
            r_dy <= i_dy;
        end
    end

    sit_prod #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .o_ready (prod_ready),
        .i_ax    (r_ax),
        .i_ay    (r_ay),
        .i_bx    (r_bx),
        .i_by    (r_by),
        .i_cx    (r_cx),
        .i_cy    (r_cy),
        .i_dx    (r_dx),
        .i_dy    (r_dy),
        .o_valid (prod_valid),
        .i_ready (dec_ready),
        .o_lhs   (prod_lhs),
        .o_rhs   (prod_rhs),
        .o_flags (prod_flags)
    );

    sit_decide #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_decide (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (prod_valid),
        .o_ready      (dec_ready),
        .i_lhs        (prod_lhs),
        .i_rhs        (prod_rhs),
        .i_flags      (prod_flags),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_intersects (o_intersects)
    );

    `ASSERT_NR(a_rst_empties_out, i_clk, !i_rst_n |=> !o_valid, "result valid right after reset")
    `ASSERT_CLK(a_full_stall_blocks, i_clk, i_rst_n, (r_in_valid && prod_valid && o_valid && !i_ready) |-> !o_ready, "input taken while pipeline full and stalled")
    `ASSERT_CLK(a_accept_loads, i_clk, i_rst_n, (i_valid && o_ready) |=> r_in_valid, "accepted beat lost at input register")

endmodule

`default_nettype wire
